// ===== hw/rtl/ssf_pkg.sv =====
// Shared types and constants for the slot store with free list.
// Holds field widths, stream packing, function and status codes, and the
// command struct that links the front and back parts. No dependencies.
`timescale 1ns / 1ps

package ssf_pkg;

    // Field widths of one request and one result.
    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 10;
    localparam int VALUE_W  = 32;
    localparam int FILL_W   = 11;
    localparam int STATUS_W = 2;

    // Stream packing: fields from the lowest bit up, padded to whole bytes.
    localparam int IN_FIELDS_W  = SLOT_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + VALUE_W + FILL_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam int OUT_SLOT_LSB   = 0;
    localparam int OUT_VALUE_LSB  = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_FILL_LSB   = OUT_VALUE_LSB + VALUE_W;
    localparam int OUT_STATUS_LSB = OUT_FILL_LSB + FILL_W;

    // Function codes as they arrive on the request stream.
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_IDX = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REM_VAL = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Decoded operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SET,
        OP_REM_IDX,
        OP_REM_VAL,
        OP_GET,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    // Control from the back part to the front part.
    typedef struct packed {
        logic pop;   // back takes the command at the queue head
        logic hold;  // back is busy with the post-reset clearing pass
    } t_back_ctl;

endpackage

// ===== hw/rtl/ssf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the data words, the free marks and the free stack. No dependencies.
`timescale 1ns / 1ps

module ssf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ssf_front.sv =====
// Front part: accepts requests, decodes the function code and queues commands.
// Depends on ssf_pkg for the command struct and codes.
`timescale 1ns / 1ps

module ssf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [ssf_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic [ssf_pkg::FUNC_W-1:0]   i_s_tuser,
    input  ssf_pkg::t_back_ctl           i_ctl,
    output logic                         o_cmd_valid,
    output ssf_pkg::t_cmd                o_cmd
);

    import ssf_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       dec_cmd;
    logic       push;

    always_comb begin
        dec_cmd.slot  = i_s_tdata[SLOT_W-1:0];
        dec_cmd.value = i_s_tdata[SLOT_W +: VALUE_W];
        case (i_s_tuser)
            FUNC_ADD:     dec_cmd.op = OP_ADD;
            FUNC_SET:     dec_cmd.op = OP_SET;
            FUNC_REM_IDX: dec_cmd.op = OP_REM_IDX;
            FUNC_REM_VAL: dec_cmd.op = OP_REM_VAL;
            FUNC_GET:     dec_cmd.op = OP_GET;
            FUNC_CLEAR:   dec_cmd.op = OP_CLEAR;
            default:      dec_cmd.op = OP_NOP;
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'(QDEPTH)) && !i_ctl.hold;
    assign push        = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_ctl.pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_ctl.pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_ctl.pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec_cmd;
        end
    end

endmodule

// ===== hw/rtl/ssf_back.sv =====
// Back part: sequencer that carries out one command at a time on the data,
// free-mark and free-stack RAMs, and holds the result register.
// Depends on ssf_pkg and ssf_ram.
`timescale 1ns / 1ps

module ssf_back #(
    parameter int CAPACITY     = 1024,
    parameter int INITIAL_SIZE = 512,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  ssf_pkg::t_cmd                  i_cmd,
    output ssf_pkg::t_back_ctl             o_ctl,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ssf_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [ssf_pkg::VALUE_W-1:0]    o_read_value,
    output logic [ssf_pkg::FILL_W-1:0]     o_fill_level,
    output logic [ssf_pkg::STATUS_W-1:0]   o_status
);

    import ssf_pkg::*;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int FILL_RST = (INITIAL_SIZE > CAPACITY) ? CAPACITY : INITIAL_SIZE;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_POP  = 3'd2;
    localparam logic [2:0] ST_MARK = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_READ = 3'd5;
    localparam logic [2:0] ST_WIPE = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]            r_state,    n_state;
    logic [CNT_W-1:0]      r_fill,     n_fill;
    logic [CNT_W-1:0]      r_top,      n_top;
    logic [CNT_W-1:0]      r_ptr,      n_ptr;
    logic                  r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]      r_chk_ptr,  n_chk_ptr;
    logic [IDX_W-1:0]      r_target,   n_target;
    logic [IDX_W-1:0]      r_slot_res, n_slot_res;
    logic [DATA_WIDTH-1:0] r_rd,       n_rd;
    logic [STATUS_W-1:0]   r_status,   n_status;
    logic [DATA_WIDTH-1:0] r_cmd_data, n_cmd_data;

    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_out_slot,  n_out_slot;
    logic [VALUE_W-1:0]    r_out_rd,    n_out_rd;
    logic [FILL_W-1:0]     r_out_fill,  n_out_fill;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    logic                  d_we;
    logic [IDX_W-1:0]      d_waddr;
    logic [DATA_WIDTH-1:0] d_wdata;
    logic [IDX_W-1:0]      d_raddr;
    logic [DATA_WIDTH-1:0] d_rdata;
    logic                  m_we;
    logic [IDX_W-1:0]      m_waddr;
    logic                  m_wdata;
    logic [IDX_W-1:0]      m_raddr;
    logic                  m_rdata;
    logic                  s_we;
    logic [IDX_W-1:0]      s_waddr;
    logic [IDX_W-1:0]      s_wdata;
    logic [IDX_W-1:0]      s_raddr;
    logic [IDX_W-1:0]      s_rdata;

    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_addr;
    logic [DATA_WIDTH-1:0] cmd_data;

    assign slot_ok   = CMP_W'(i_cmd.slot) < CMP_W'(r_fill);
    assign slot_addr = IDX_W'(i_cmd.slot);
    assign cmd_data  = DATA_WIDTH'(i_cmd.value);

    ssf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    ssf_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    ssf_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_top        = r_top;
        n_ptr        = r_ptr;
        n_chk_valid  = r_chk_valid;
        n_chk_ptr    = r_chk_ptr;
        n_target     = r_target;
        n_slot_res   = r_slot_res;
        n_rd         = r_rd;
        n_status     = r_status;
        n_cmd_data   = r_cmd_data;
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_rd     = r_out_rd;
        n_out_fill   = r_out_fill;
        n_out_status = r_out_status;

        o_ctl.pop  = 1'b0;
        o_ctl.hold = 1'b0;

        d_we    = 1'b0;
        d_waddr = '0;
        d_wdata = '0;
        d_raddr = '0;
        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = 1'b0;
        m_raddr = '0;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_INIT: begin
                // Zero every data word and free mark, one entry a cycle.
                o_ctl.hold = 1'b1;
                d_we       = 1'b1;
                d_waddr    = r_ptr[IDX_W-1:0];
                m_we       = 1'b1;
                m_waddr    = r_ptr[IDX_W-1:0];
                if (r_ptr == CNT_W'(CAPACITY - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_ctl.pop  = 1'b1;
                    n_cmd_data = cmd_data;
                    n_slot_res = '0;
                    n_rd       = '0;
                    n_status   = STATUS_OK;
                    n_state    = ST_DONE;
                    case (i_cmd.op)
                        OP_ADD: begin
                            if (r_top != '0) begin
                                s_raddr = IDX_W'(r_top - CNT_W'(1));
                                n_state = ST_POP;
                            end else if (r_fill < CNT_W'(CAPACITY)) begin
                                d_we       = 1'b1;
                                d_waddr    = r_fill[IDX_W-1:0];
                                d_wdata    = cmd_data;
                                n_slot_res = r_fill[IDX_W-1:0];
                                n_fill     = r_fill + CNT_W'(1);
                            end else begin
                                n_status = STATUS_FULL;
                            end
                        end
                        OP_SET: begin
                            if (slot_ok) begin
                                d_we    = 1'b1;
                                d_waddr = slot_addr;
                                d_wdata = cmd_data;
                            end else begin
                                n_status = STATUS_RANGE;
                            end
                        end
                        OP_REM_IDX: begin
                            if (slot_ok) begin
                                m_raddr  = slot_addr;
                                n_target = slot_addr;
                                n_state  = ST_MARK;
                            end else begin
                                n_status = STATUS_RANGE;
                            end
                        end
                        OP_REM_VAL: begin
                            n_ptr       = '0;
                            n_chk_valid = 1'b0;
                            n_state     = ST_SCAN;
                        end
                        OP_GET: begin
                            if (slot_ok) begin
                                d_raddr = slot_addr;
                                n_state = ST_READ;
                            end else begin
                                n_status = STATUS_RANGE;
                            end
                        end
                        OP_CLEAR: begin
                            n_ptr   = '0;
                            n_state = ST_WIPE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                // Reuse the most recently freed slot.
                d_we       = 1'b1;
                d_waddr    = s_rdata;
                d_wdata    = r_cmd_data;
                m_we       = 1'b1;
                m_waddr    = s_rdata;
                m_wdata    = 1'b0;
                n_top      = r_top - CNT_W'(1);
                n_slot_res = s_rdata;
                n_state    = ST_DONE;
            end
            ST_MARK: begin
                if (m_rdata) begin
                    n_status = STATUS_NOT_FOUND;
                end else begin
                    s_we    = 1'b1;
                    s_waddr = r_top[IDX_W-1:0];
                    s_wdata = r_target;
                    m_we    = 1'b1;
                    m_waddr = r_target;
                    m_wdata = 1'b1;
                    n_top   = r_top + CNT_W'(1);
                end
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // One read issued per cycle; the word read in the previous
                // cycle is compared now, so the lowest match wins.
                d_raddr = r_ptr[IDX_W-1:0];
                if (r_chk_valid && (d_rdata == r_cmd_data)) begin
                    n_target   = r_chk_ptr;
                    n_slot_res = r_chk_ptr;
                    m_raddr    = r_chk_ptr;
                    n_state    = ST_MARK;
                end else if (r_ptr < r_fill) begin
                    n_chk_valid = 1'b1;
                    n_chk_ptr   = r_ptr[IDX_W-1:0];
                    n_ptr       = r_ptr + CNT_W'(1);
                end else begin
                    n_status   = STATUS_NOT_FOUND;
                    n_slot_res = '0;
                    n_state    = ST_DONE;
                end
            end
            ST_READ: begin
                n_rd    = d_rdata;
                n_state = ST_DONE;
            end
            ST_WIPE: begin
                // Marks can only be set below the fill level, so the wipe
                // stops there.
                if (r_ptr < r_fill) begin
                    m_we    = 1'b1;
                    m_waddr = r_ptr[IDX_W-1:0];
                    m_wdata = 1'b0;
                    n_ptr   = r_ptr + CNT_W'(1);
                end else begin
                    n_fill  = '0;
                    n_top   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = SLOT_W'(r_slot_res);
                    n_out_rd     = VALUE_W'(r_rd);
                    n_out_fill   = FILL_W'(r_fill);
                    n_out_status = r_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_fill      <= CNT_W'(FILL_RST);
            r_top       <= '0;
            r_ptr       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_top       <= n_top;
            r_ptr       <= n_ptr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_ptr    <= n_chk_ptr;
        r_target     <= n_target;
        r_slot_res   <= n_slot_res;
        r_rd         <= n_rd;
        r_status     <= n_status;
        r_cmd_data   <= n_cmd_data;
        r_out_slot   <= n_out_slot;
        r_out_rd     <= n_out_rd;
        r_out_fill   <= n_out_fill;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_out   = r_out_slot;
    assign o_read_value = r_out_rd;
    assign o_fill_level = r_out_fill;
    assign o_status     = r_out_status;

endmodule

// ===== hw/rtl/slot_store_with_free_list_unit.sv =====
// Top level of the slot store with free list: request and result streams.
// Depends on ssf_pkg, ssf_front and ssf_back (which uses ssf_ram).
`timescale 1ns / 1ps

// The unit keeps up to CAPACITY data words in numbered slots and a LIFO list
// of freed slots. Each request carries a function code in s_tuser and a slot
// index and data word in s_tdata; each request yields exactly one result with
// the slot used or found, the word read by get, the fill level afterwards and
// a status code. Requests enter a two-deep command queue, so the request side
// keeps flowing while a result waits in the output register. An add that
// appends, a set, an add to a full store, a request whose index is out of
// range and a request with an undefined function code need no RAM read;
// an add that reuses a freed slot, a remove by index of a slot in range and
// a get each need one registered read of a slot RAM before they can finish.
// A remove by value reads the data RAM one slot per cycle from slot 0 until
// the first match or the fill level. A clear wipes the free marks one entry
// per cycle up to the fill level. After reset the unit zeroes its data and
// mark RAMs in a clearing pass, during which s_tready stays low; the store
// then holds INITIAL_SIZE zero words, capped at CAPACITY.
module slot_store_with_free_list_unit #(
    parameter int CAPACITY     = 1024,
    parameter int INITIAL_SIZE = 512,
    parameter int DATA_WIDTH   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // s_tdata fields from bit 0: slot [9:0], value [41:10], zero padding.
    input  logic [ssf_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // s_tuser fields from bit 0: func [2:0].
    input  logic [ssf_pkg::FUNC_W-1:0]      i_s_tuser,
    // Result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // m_tdata fields from bit 0: slot_out [9:0], read_value [41:10],
    // fill_level [52:42], status [54:53], zero padding.
    output logic [ssf_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    import ssf_pkg::*;

    logic                cmd_valid;
    t_cmd                cmd;
    t_back_ctl           back_ctl;
    logic [SLOT_W-1:0]   slot_out;
    logic [VALUE_W-1:0]  read_value;
    logic [FILL_W-1:0]   fill_level;
    logic [STATUS_W-1:0] status;

    // Front: decode the function code and queue the command.
    ssf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_ctl       (back_ctl),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Back: execute commands against the RAMs and register the result.
    ssf_back #(
        .CAPACITY     (CAPACITY),
        .INITIAL_SIZE (INITIAL_SIZE),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_ctl        (back_ctl),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_slot_out   (slot_out),
        .o_read_value (read_value),
        .o_fill_level (fill_level),
        .o_status     (status)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, status, fill_level, read_value, slot_out};

endmodule

// ===== hw/rtl/ssf_checker.sv =====
// Port-level checker for the slot store with free list, bound to the top level.
// Depends on ssf_pkg for field positions and status codes.
`timescale 1ns / 1ps

module ssf_checker #(
    parameter int CAPACITY = 1024
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [ssf_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic [ssf_pkg::FUNC_W-1:0]      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ssf_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    import ssf_pkg::*;

    logic [SLOT_W-1:0]   slot_out;
    logic [VALUE_W-1:0]  read_value;
    logic [FILL_W-1:0]   fill_level;
    logic [STATUS_W-1:0] status;
    logic                in_acc;
    logic                out_acc;
    logic [2:0]          r_pending;

    assign slot_out   = o_m_tdata[OUT_SLOT_LSB +: SLOT_W];
    assign read_value = o_m_tdata[OUT_VALUE_LSB +: VALUE_W];
    assign fill_level = o_m_tdata[OUT_FILL_LSB +: FILL_W];
    assign status     = o_m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = o_m_tvalid && i_m_tready;

    // Requests taken whose results are not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No result without a request behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != 3'd0)
        else $error("result without a pending request");

    // A full store reports the fill level at capacity.
    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status == STATUS_FULL |-> fill_level == FILL_W'(CAPACITY))
        else $error("store full reported below capacity");

    // A rejected index yields no slot and no data.
    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status == STATUS_RANGE |-> slot_out == '0 && read_value == '0)
        else $error("out-of-range result carries a slot or data");

    // Data only comes back from a successful get.
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && read_value != '0 |-> status == STATUS_OK)
        else $error("read data with a failing status");

endmodule

bind slot_store_with_free_list_unit ssf_checker #(.CAPACITY(CAPACITY)) u_ssf_checker (.*);

// ===== bench/ssf_tb_pkg.sv =====
// Result checker for the slot store with free list testbench.
// Mirrors the store, its free list and its fill level, and queues the result
// each request owes. Depends on ssf_pkg for field widths, codes and packing.
`timescale 1ns / 1ps

package ssf_tb_pkg;

    import ssf_pkg::*;

    localparam int STORE_CAPACITY = 1024;
    localparam int INITIAL_FILL   = 512;
    localparam int REPORT_LIMIT   = 10;

    // Function codes that the block decodes as no operation.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic [VALUE_W-1:0]  read_value;
        logic [FILL_W-1:0]   fill_level;
        logic [STATUS_W-1:0] status;
    } t_slot_result;

    class slot_store_mirror;

        logic [VALUE_W-1:0] slot_data [STORE_CAPACITY];
        logic [SLOT_W-1:0]  free_stack [STORE_CAPACITY];
        bit                 free_mark [STORE_CAPACITY];
        logic [FILL_W-1:0]  free_top;
        logic [FILL_W-1:0]  fill_count;
        t_slot_result       owed_results [$];
        int                 mismatch_count;
        int                 results_seen;

        function new();
            for (int i = 0; i < STORE_CAPACITY; i++) begin
                slot_data[i] = '0;
                free_stack[i] = '0;
                free_mark[i] = 1'b0;
            end
            free_top = '0;
            fill_count = FILL_W'((INITIAL_FILL > STORE_CAPACITY) ? STORE_CAPACITY
                                                                 : INITIAL_FILL);
            mismatch_count = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void push_free(input logic [SLOT_W-1:0] slot);
            if (free_top < STORE_CAPACITY) begin
                free_stack[free_top] = slot;
                free_top = free_top + 1'b1;
                free_mark[slot] = 1'b1;
            end
        endfunction

        // Applies one accepted request to the mirror and queues its result.
        function void apply_request(input logic [FUNC_W-1:0] func,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [VALUE_W-1:0] value);
            t_slot_result      want;
            logic [SLOT_W-1:0] reused;
            int                hit;
            want = '0;
            case (func)
                FUNC_ADD: begin
                    if (free_top != 0) begin
                        free_top = free_top - 1'b1;
                        reused = free_stack[free_top];
                        free_mark[reused] = 1'b0;
                        slot_data[reused] = value;
                        want.slot_out = reused;
                    end else if (fill_count < STORE_CAPACITY) begin
                        slot_data[fill_count] = value;
                        want.slot_out = fill_count[SLOT_W-1:0];
                        fill_count = fill_count + 1'b1;
                    end else begin
                        want.status = STATUS_FULL;
                    end
                end
                FUNC_SET: begin
                    if (slot < fill_count) slot_data[slot] = value;
                    else want.status = STATUS_RANGE;
                end
                FUNC_REM_IDX: begin
                    if (slot >= fill_count) want.status = STATUS_RANGE;
                    else if (free_mark[slot]) want.status = STATUS_NOT_FOUND;
                    else push_free(slot);
                end
                FUNC_REM_VAL: begin
                    hit = -1;
                    for (int i = 0; i < fill_count; i++) begin
                        if (hit < 0 && slot_data[i] == value) hit = i;
                    end
                    if (hit < 0) begin
                        want.status = STATUS_NOT_FOUND;
                    end else begin
                        // A matching slot is named even when it is already free.
                        want.slot_out = hit[SLOT_W-1:0];
                        if (free_mark[hit]) want.status = STATUS_NOT_FOUND;
                        else push_free(hit[SLOT_W-1:0]);
                    end
                end
                FUNC_GET: begin
                    if (slot < fill_count) want.read_value = slot_data[slot];
                    else want.status = STATUS_RANGE;
                end
                FUNC_CLEAR: begin
                    fill_count = '0;
                    free_top = '0;
                    for (int i = 0; i < STORE_CAPACITY; i++) free_mark[i] = 1'b0;
                end
                default: begin
                end
            endcase
            want.fill_level = fill_count;
            owed_results = {owed_results, want};
        endfunction

        function void report(input string field, input logic [63:0] want,
                             input logic [63:0] got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch at result %0d: %s expected %h got %h",
                         results_seen, field, want, got);
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] word);
            t_slot_result got;
            t_slot_result want;
            got.slot_out   = word[OUT_SLOT_LSB +: SLOT_W];
            got.read_value = word[OUT_VALUE_LSB +: VALUE_W];
            got.fill_level = word[OUT_FILL_LSB +: FILL_W];
            got.status     = word[OUT_STATUS_LSB +: STATUS_W];
            results_seen++;
            if (owed_results.size() == 0) begin
                report("result with no request waiting, tdata", '0, word);
                return;
            end
            want = owed_results.pop_front();
            if (got.slot_out !== want.slot_out)
                report("slot_out", want.slot_out, got.slot_out);
            if (got.read_value !== want.read_value)
                report("read_value", want.read_value, got.read_value);
            if (got.fill_level !== want.fill_level)
                report("fill_level", want.fill_level, got.fill_level);
            if (got.status !== want.status)
                report("status", want.status, got.status);
        endfunction

    endclass

endpackage

// ===== bench/tb_slot_store_with_free_list_unit.sv =====
// Testbench top for slot_store_with_free_list_unit: directed and random
// requests under random idling on both streams. Depends on ssf_pkg,
// ssf_tb_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_slot_store_with_free_list_unit;

    import ssf_pkg::*;
    import ssf_tb_pkg::*;

    // One remove by value over a full store or one clear of a full store is the
    // slowest request, so this settle time covers the slowest request the block
    // can still be working on.
    localparam int SETTLE_CYCLES    = 1100;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 125;
    // Far beyond the slowest correct run, which is dominated by full scans.
    localparam longint TIMEOUT_NS   = 100_000_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [FUNC_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    slot_store_mirror sb;

    // Idle rates in percent of cycles; the result side reads its rate at clock
    // edges, so the main sequence updates it with nonblocking assignments.
    int send_idle_pct = 25;
    int recv_idle_pct = 71;
    // A long hold of the result side is requested once here; the result
    // process takes it and counts it down itself.
    logic long_hold_req   = 1'b0;
    logic long_hold_taken = 1'b0;
    int   hold_left       = 0;

    slot_store_with_free_list_unit #(
        .CAPACITY     (STORE_CAPACITY),
        .INITIAL_SIZE (INITIAL_FILL),
        .DATA_WIDTH   (VALUE_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side. The handshake is sampled at the edge before this process
    // drives the ready for the next cycle, so every result is seen exactly
    // once and checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request and returns in the time step of the edge that takes
    // it. The valid is only lowered when an idle gap is chosen, so a back to
    // back request never sees the valid dropped and raised in one step.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [SLOT_W-1:0] slot,
                                input logic [VALUE_W-1:0] value);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[SLOT_W-1:0] = slot;
        word[SLOT_W +: VALUE_W] = value;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.apply_request(func, slot, value);
    endtask

    // The sender goes quiet until every owed result has come back.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pool_value(input int pick);
        case (pick)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4:       return 32'h5A5A_5A5A;
            5:       return 32'hA5A5_A5A5;
            6:       return 32'h1234_5678;
            default: return 32'h0000_FFFF;
        endcase
    endfunction

    // Random request shaped by the mirrored state: most indexes land below
    // the fill level, some at it, and the rest anywhere. Values come from a small
    // pool, from words already stored (so removes by value with such a word hit), or
    // from the full 32-bit range.
    task automatic send_random_request();
        int                 pick;
        int                 fill;
        logic [FUNC_W-1:0]  func;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        fill = int'(sb.fill_count);
        pick = $urandom_range(99);
        if (fill > 0 && pick < 75) slot = SLOT_W'($urandom_range(fill - 1));
        else if (pick < 85 && fill < STORE_CAPACITY) slot = SLOT_W'(fill);
        else slot = SLOT_W'($urandom_range(STORE_CAPACITY - 1));
        case ($urandom_range(3))
            0:       value = $urandom();
            1:       value = (fill > 0) ? sb.slot_data[$urandom_range(fill - 1)]
                                        : pool_value($urandom_range(7));
            default: value = pool_value($urandom_range(7));
        endcase
        pick = $urandom_range(199);
        if (pick < 60) func = FUNC_ADD;
        else if (pick < 90) func = FUNC_SET;
        else if (pick < 120) func = FUNC_REM_IDX;
        else if (pick < 140) func = FUNC_REM_VAL;
        else if (pick < 190) func = FUNC_GET;
        else if (pick < 194) func = FUNC_CLEAR;
        else if (pick < 197) func = FUNC_UNUSED_LO;
        else func = FUNC_UNUSED_HI;
        send_request(func, slot, value);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= FUNC_ADD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests. The store starts with 512 zero words and an
        // empty free list; the clearing pass after reset simply holds off
        // the first request.
        send_request(FUNC_GET, 10'd0, 32'h0);
        send_request(FUNC_GET, 10'd511, 32'h0);
        send_request(FUNC_GET, 10'd512, 32'h0);            // at the fill level
        send_request(FUNC_SET, 10'd0, 32'hFFFF_FFFF);
        send_request(FUNC_SET, 10'd512, 32'h0000_0001);    // out of range
        send_request(FUNC_GET, 10'd0, 32'h0);
        send_request(FUNC_ADD, 10'd0, 32'hA5A5_A5A5);      // appends at 512
        send_request(FUNC_GET, 10'd512, 32'h0);
        send_request(FUNC_REM_IDX, 10'd5, 32'h0);
        send_request(FUNC_REM_IDX, 10'd5, 32'h0);          // slot already free
        send_request(FUNC_REM_IDX, 10'd1023, 32'h0);       // out of range
        send_request(FUNC_SET, 10'd5, 32'hDEAD_BEEF);      // write to a free slot
        send_request(FUNC_GET, 10'd5, 32'h0);
        send_request(FUNC_ADD, 10'd0, 32'h0000_FFFF);      // reuses slot 5
        send_request(FUNC_REM_VAL, 10'd0, 32'hFFFF_FFFF);  // finds slot 0
        send_request(FUNC_REM_VAL, 10'd0, 32'hFFFF_FFFF);  // match is already free
        send_request(FUNC_REM_VAL, 10'd0, 32'h0000_0000);  // lowest zero is slot 1
        send_request(FUNC_REM_VAL, 10'd0, 32'h7777_7777);  // no match at all
        send_request(FUNC_UNUSED_LO, 10'd1023, 32'hFFFF_FFFF);
        send_request(FUNC_UNUSED_HI, 10'd0, 32'h0);
        send_request(FUNC_ADD, 10'd0, 32'h0000_0001);      // last freed first: slot 1
        send_request(FUNC_CLEAR, 10'd0, 32'h0);
        send_request(FUNC_GET, 10'd0, 32'h0);              // empty store
        send_request(FUNC_REM_VAL, 10'd0, 32'h0);          // nothing to search
        send_request(FUNC_ADD, 10'd0, 32'h1234_5678);      // overwrites stale slot 0

        // The result side holds off for a long stretch while requests keep
        // coming, so the command queue and output register fill and the
        // request side stalls.
        long_hold_req <= 1'b1;
        repeat (RANDOM_PER_PHASE) send_random_request();
        wait_for_results();

        // Roles swapped: a slow sender and a mostly ready receiver.
        send_idle_pct = 71;
        recv_idle_pct <= 25;
        repeat (RANDOM_PER_PHASE) send_random_request();
        wait_for_results();

        // No idling from here on.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        repeat (RANDOM_PER_PHASE) send_random_request();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
